>>> rtl/dlsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dlsd_pkg - dive log sample decoder package
// shared types, register indexes and field constants
// ---------------------------------------------------------------------------
package dlsd_pkg;

    // configuration port index width (wider than the register list)
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FREEDIVE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_PRES = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAS_KNOWN  = 4'd3;

    localparam logic [1:0] FMT_TWO_BYTE   = 2'd0;
    localparam logic [1:0] FMT_THREE_BYTE = 2'd1;
    localparam logic [1:0] FMT_FIVE_BYTE  = 2'd2;

    localparam logic [15:0] DEPTH_MASK  = 16'h07FF;
    localparam logic [5:0]  DIVE_STEP_S = 6'd20;
    localparam logic [1:0]  PHASE_LAST  = 2'd2;

    typedef struct packed {
        logic        freedive_session;
        logic [1:0]  record_format;
        logic [15:0] start_pressure_centibar;
        logic        gas_known;
    } cfg_t;

    typedef struct packed {
        logic [15:0] sample_word;
        logic [7:0]  aux_byte_a;
        logic [7:0]  aux_byte_b;
        logic [7:0]  aux_byte_c;
        logic [7:0]  aux_byte_d;
        logic        final_record;
    } item_t;

    typedef struct packed {
        logic [31:0] time_s;
        logic [15:0] depth_dm;
        logic [1:0]  ascent_level;
        logic        ceiling_violation;
        logic        deco_stop;
        logic        gas_change;
        logic        pressure_valid;
        logic [15:0] pressure_centibar;
        logic        dive_end;
        logic        last;
    } result_t;

endpackage
`default_nettype wire

>>> rtl/dlsd_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dlsd_core - record decode and dive state
// decodes one registered record into one or two results and updates the
// per-dive state (elapsed time, tank pressure, pressure phase, gas flag)
// ---------------------------------------------------------------------------
module dlsd_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dlsd_pkg::cfg_t    cfg,
    input  wire dlsd_pkg::item_t   item,
    input  wire logic             advance,
    output dlsd_pkg::result_t      res_first,
    output dlsd_pkg::result_t      res_second,
    output logic                  two_results
);
    import dlsd_pkg::*;

    logic [31:0] time_reg,  time_next;
    logic [15:0] press_reg, press_next;
    logic [1:0]  phase_reg, phase_next;
    logic        gas_reg,   gas_next;
    logic        open_reg,  open_next;

    logic [15:0] press_base;
    logic [13:0] surf_s;
    logic [13:0] dive_s;
    logic [14:0] both_s;
    logic [32:0] sum_surf;
    logic [32:0] sum_both;
    logic [32:0] sum_step;
    logic [31:0] t_surf;
    logic [31:0] t_both;
    logic [31:0] t_step;
    logic [14:0] drop;
    logic [15:0] press_drop;
    logic [1:0]  phase_adv;
    logic        announce;

    always_comb
    begin
        press_base = open_reg ? press_reg : cfg.start_pressure_centibar;

        // minutes * 60 as (m << 6) - (m << 2)
        surf_s = {6'd0, item.aux_byte_c}
               + ({item.aux_byte_d, 6'd0} - {4'd0, item.aux_byte_d, 2'd0});
        dive_s = {6'd0, item.aux_byte_a}
               + ({item.aux_byte_b, 6'd0} - {4'd0, item.aux_byte_b, 2'd0});
        both_s = {1'b0, surf_s} + {1'b0, dive_s};

        // saturating adds, both freedive points taken from the old time
        sum_surf = {1'b0, time_reg} + {19'd0, surf_s};
        sum_both = {1'b0, time_reg} + {18'd0, both_s};
        sum_step = {1'b0, time_reg} + {27'd0, DIVE_STEP_S};
        t_surf   = sum_surf[32] ? '1 : sum_surf[31:0];
        t_both   = sum_both[32] ? '1 : sum_both[31:0];
        t_step   = sum_step[32] ? '1 : sum_step[31:0];

        // byte * 100 as (b << 6) + (b << 5) + (b << 2)
        drop = {1'b0, item.aux_byte_a, 6'd0} + {2'd0, item.aux_byte_a, 5'd0}
             + {5'd0, item.aux_byte_a, 2'd0};
        press_drop = ({1'b0, drop} > press_base) ? 16'd0 : press_base - {1'b0, drop};

        phase_adv = (phase_reg >= PHASE_LAST) ? 2'd0 : phase_reg + 2'd1;
        announce  = cfg.gas_known && !gas_reg;

        res_first  = '0;
        res_second = '0;
        time_next  = time_reg;
        press_next = press_base;
        phase_next = phase_reg;
        gas_next   = gas_reg;
        open_next  = 1'b1;

        if (cfg.freedive_session)
        begin
            two_results          = 1'b1;
            res_first.time_s     = t_surf;
            res_first.dive_end   = item.final_record;
            res_second.time_s    = t_both;
            res_second.depth_dm  = item.sample_word;
            res_second.dive_end  = item.final_record;
            res_second.last      = 1'b1;
            time_next            = t_both;
        end
        else
        begin
            two_results                 = 1'b0;
            res_first.time_s            = t_step;
            res_first.depth_dm          = item.sample_word & DEPTH_MASK;
            res_first.ascent_level      = item.sample_word[15:14];
            res_first.ceiling_violation = item.sample_word[13];
            res_first.deco_stop         = item.sample_word[12];
            res_first.gas_change        = announce;
            res_first.dive_end          = item.final_record;
            res_first.last              = 1'b1;
            time_next                   = t_step;
            phase_next                  = phase_adv;
            if (announce)
                gas_next = 1'b1;
            case (cfg.record_format)
                FMT_THREE_BYTE:
                begin
                    res_first.pressure_valid    = 1'b1;
                    res_first.pressure_centibar = {1'b0, drop};
                end
                FMT_FIVE_BYTE:
                begin
                    if (phase_adv == 2'd0)
                    begin
                        press_next                  = press_drop;
                        res_first.pressure_valid    = 1'b1;
                        res_first.pressure_centibar = press_drop;
                    end
                end
                default:
                begin
                    res_first.pressure_valid = 1'b0;
                end
            endcase
        end

        // final record closes the dive
        if (item.final_record)
        begin
            time_next  = '0;
            press_next = cfg.start_pressure_centibar;
            phase_next = '0;
            gas_next   = 1'b0;
            open_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg  <= '0;
            press_reg <= '0;
            phase_reg <= '0;
            gas_reg   <= 1'b0;
            open_reg  <= 1'b0;
        end
        else if (advance)
        begin
            time_reg  <= time_next;
            press_reg <= press_next;
            phase_reg <= phase_next;
            gas_reg   <= gas_next;
            open_reg  <= open_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/dlsd_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dlsd_out_buf - two-entry result buffer
// holds the one or two results of a record and hands them out in order
// ---------------------------------------------------------------------------
module dlsd_out_buf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire dlsd_pkg::result_t res_first,
    input  wire dlsd_pkg::result_t res_second,
    input  wire logic             two_results,
    input  wire logic             stall,
    output logic                  can_load,
    output logic                  valid,
    output dlsd_pkg::result_t      head
);
    import dlsd_pkg::*;

    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic [1:0] cnt_reg,   cnt_next;
    logic       pop;

    always_comb
    begin
        valid    = (cnt_reg != 2'd0);
        head     = slot0_reg;
        pop      = valid && !stall;
        can_load = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);

        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (load)
        begin
            slot0_next = res_first;
            slot1_next = res_second;
            cnt_next   = two_results ? 2'd2 : 2'd1;
        end
        else if (pop)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule
`default_nettype wire

>>> rtl/dive_log_sample_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dive_log_sample_decoder - profile record decoder
// turns raw dive log records into timed depth, flag and pressure results
// ---------------------------------------------------------------------------
// usage:
//   input channel: in_valid / in_stall with one record per transaction
//   output channel: out_valid / out_stall with one result per transaction
//   config channel: cfg_valid / cfg_ready / cfg_index / cfg_data, always
//     ready; write only while no record is in flight
//   an accepted record passes the input register, then the result buffer,
//     and waits in the input register while the buffer cannot load
//   throughput: one record per cycle in dive mode while out_stall is low;
//     freedive records give two results each, so the single output port
//     admits a new record only as the previous second result leaves
//   the input register is taken again in the cycle its record moves into
//     the result buffer, so records stream while results are drained
//   out_stall holds the result buffer; once it cannot load and the
//     input register is full, in_stall rises and the record waits unchanged
//   reset clears dive state, empties both stages and loads the register
//     reset values (gas_known set, all others zero)
// ---------------------------------------------------------------------------
module dive_log_sample_decoder (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [dlsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                     cfg_data,
    // record input
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [15:0]                     sample_word,
    input  wire logic [7:0]                      aux_byte_a,
    input  wire logic [7:0]                      aux_byte_b,
    input  wire logic [7:0]                      aux_byte_c,
    input  wire logic [7:0]                      aux_byte_d,
    input  wire logic                            final_record,
    // result output
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [31:0]                          time_s,
    output logic [15:0]                          depth_dm,
    output logic [1:0]                           ascent_level,
    output logic                                 ceiling_violation,
    output logic                                 deco_stop,
    output logic                                 gas_change,
    output logic                                 pressure_valid,
    output logic [15:0]                          pressure_centibar,
    output logic                                 dive_end,
    output logic                                 last
);
    import dlsd_pkg::*;

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    in_vld_reg, in_vld_next;
    logic    advance;
    logic    can_load;
    logic    in_take;
    logic    two_results;
    result_t res_first;
    result_t res_second;
    result_t head;

    // configuration registers, write always completes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.freedive_session        <= 1'b0;
            cfg_reg.record_format           <= FMT_TWO_BYTE;
            cfg_reg.start_pressure_centibar <= '0;
            cfg_reg.gas_known               <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FREEDIVE:   cfg_reg.freedive_session        <= cfg_data[0];
                REG_FORMAT:     cfg_reg.record_format           <= cfg_data[1:0];
                REG_START_PRES: cfg_reg.start_pressure_centibar <= cfg_data[15:0];
                REG_GAS_KNOWN:  cfg_reg.gas_known               <= cfg_data[0];
                default:        cfg_reg                         <= cfg_reg;
            endcase
        end
    end

    // input register: refilled in the same cycle its record moves on
    assign advance  = in_vld_reg && can_load;
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.sample_word  <= sample_word;
            item_reg.aux_byte_a   <= aux_byte_a;
            item_reg.aux_byte_b   <= aux_byte_b;
            item_reg.aux_byte_c   <= aux_byte_c;
            item_reg.aux_byte_d   <= aux_byte_d;
            item_reg.final_record <= final_record;
        end
    end

    // decode and dive state, committed when the record moves on
    dlsd_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .item        (item_reg),
        .advance     (advance),
        .res_first   (res_first),
        .res_second  (res_second),
        .two_results (two_results)
    );

    // result buffer in front of the output channel
    dlsd_out_buf u_out_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .res_first   (res_first),
        .res_second  (res_second),
        .two_results (two_results),
        .stall       (out_stall),
        .can_load    (can_load),
        .valid       (out_valid),
        .head        (head)
    );

    assign time_s            = head.time_s;
    assign depth_dm          = head.depth_dm;
    assign ascent_level      = head.ascent_level;
    assign ceiling_violation = head.ceiling_violation;
    assign deco_stop         = head.deco_stop;
    assign gas_change        = head.gas_change;
    assign pressure_valid    = head.pressure_valid;
    assign pressure_centibar = head.pressure_centibar;
    assign dive_end          = head.dive_end;
    assign last              = head.last;

endmodule
`default_nettype wire

>>> rtl/dlsd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dlsd_checker - port-level checks
// watches the output channel of the decoder over time
// ---------------------------------------------------------------------------
module dlsd_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [31:0] time_s,
    input  wire logic [15:0] depth_dm,
    input  wire logic        gas_change,
    input  wire logic        pressure_valid,
    input  wire logic [15:0] pressure_centibar,
    input  wire logic        dive_end,
    input  wire logic        last
);

    // stalled transaction holds its time and last flag
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(time_s) && $stable(last))
        else $error("stalled result changed");

    // surface point is followed at once by its max depth point
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid && last)
        else $error("second freedive result missing");

    // surface point carries no depth, pressure or gas
    a_surface_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> depth_dm == 16'd0 && !pressure_valid && !gas_change)
        else $error("surface point carries dive fields");

    // the pair shares its dive end flag and time does not run back
    a_pair_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=>
            dive_end == $past(dive_end) && time_s >= $past(time_s))
        else $error("freedive pair inconsistent");

    a_no_pressure_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pressure_valid |-> pressure_centibar == 16'd0)
        else $error("pressure set without reading");

endmodule

bind dive_log_sample_decoder dlsd_checker u_dlsd_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .time_s            (time_s),
    .depth_dm          (depth_dm),
    .gas_change        (gas_change),
    .pressure_valid    (pressure_valid),
    .pressure_centibar (pressure_centibar),
    .dive_end          (dive_end),
    .last              (last)
);
`default_nettype wire
